// ===== rtl/core/smse_pkg.sv =====
// Shared types and codes for the sorted multi-set engine.
package smse_pkg;

  localparam int CNT_W = 7;
  localparam int ID_W  = 16;
  localparam int VAL_W = 32;

  localparam logic [3:0] MODE_INSERT = 4'd0;
  localparam logic [3:0] MODE_DELETE = 4'd1;
  localparam logic [3:0] MODE_MEMBER = 4'd2;
  localparam logic [3:0] MODE_UNION  = 4'd3;
  localparam logic [3:0] MODE_INTER  = 4'd4;
  localparam logic [3:0] MODE_SIZE   = 4'd5;
  localparam logic [3:0] MODE_DIFF   = 4'd6;
  localparam logic [3:0] MODE_SYMD   = 4'd7;
  localparam logic [3:0] MODE_LIST   = 4'd8;

  localparam logic [2:0] ST_SIZE    = 3'd0;
  localparam logic [2:0] ST_MEMBER  = 3'd1;
  localparam logic [2:0] ST_MISSING = 3'd2;
  localparam logic [2:0] ST_LISTED  = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;
  localparam logic [2:0] ST_OVF     = 3'd5;

  typedef struct packed {
    logic [3:0]              mode;
    logic [ID_W-1:0]         set_a;
    logic [ID_W-1:0]         set_b;
    logic signed [VAL_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [CNT_W-1:0]        count;
    logic                    is_member;
    logic signed [VAL_W-1:0] element;
    logic                    last_of_run;
  } rsp_t;

  typedef enum logic [2:0] {
    K_INS  = 3'd0,
    K_DEL  = 3'd1,
    K_MEM  = 3'd2,
    K_SIZE = 3'd3,
    K_TWO  = 3'd4,
    K_LIST = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic                    keep_a;
    logic                    keep_b;
    logic                    keep_both;
    logic [ID_W-1:0]         id_a;
    logic [ID_W-1:0]         id_b;
    logic signed [VAL_W-1:0] value;
  } op_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] size;
  } dir_ent_t;

endpackage

// ===== rtl/core/sorted_multi_set_engine.sv =====
// Top level of the sorted multi-set engine.
// A request is taken into a front register, classified and queued; the back end then
// runs it alone. Every request first scans the set directory, and two-set modes scan
// it twice. Insert, delete and member walk set A against the value; two-set modes walk
// A and B, up to 2*CAPACITY steps, then copy the result back through the single write
// port of the element memory. A listing gives its elements one response at a time,
// each held until the output is free to take it.
module sorted_multi_set_engine #(
  parameter int NUM_SETS = 16,
  parameter int CAPACITY = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  smse_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_stall,
  output smse_pkg::rsp_t out_rsp
);
  import smse_pkg::*;

  logic push;
  op_t  push_op;
  logic q_full;
  logic pop;
  logic q_valid;
  op_t  q_op;

  smse_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .push     (push),
    .push_op  (push_op),
    .q_full   (q_full)
  );

  smse_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_op    (q_op)
  );

  smse_back #(
    .NUM_SETS (NUM_SETS),
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

endmodule

// ===== rtl/core/smse_front.sv =====
// Front end: accepts requests, classifies the mode and hands operations to the queue.
module smse_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  smse_pkg::req_t in_req,
  output logic          push,
  output smse_pkg::op_t push_op,
  input  logic          q_full
);
  import smse_pkg::*;

  logic f_valid;
  op_t  f_op;
  op_t  cls;
  logic known;
  logic accept;

  always_comb begin
    cls       = '0;
    cls.id_a  = in_req.set_a;
    cls.id_b  = in_req.set_b;
    cls.value = in_req.item_value;
    known     = 1'b1;
    case (in_req.mode)
      MODE_INSERT: begin
        cls.kind = K_INS; cls.keep_a = 1'b1; cls.keep_b = 1'b1; cls.keep_both = 1'b1;
      end
      MODE_DELETE: begin
        cls.kind = K_DEL; cls.keep_a = 1'b1;
      end
      MODE_MEMBER: begin
        cls.kind = K_MEM; cls.keep_both = 1'b1;
      end
      MODE_SIZE: cls.kind = K_SIZE;
      MODE_UNION: begin
        cls.kind = K_TWO; cls.keep_a = 1'b1; cls.keep_b = 1'b1; cls.keep_both = 1'b1;
      end
      MODE_INTER: begin
        cls.kind = K_TWO; cls.keep_both = 1'b1;
      end
      MODE_DIFF: begin
        cls.kind = K_TWO; cls.keep_a = 1'b1;
      end
      MODE_SYMD: begin
        cls.kind = K_TWO; cls.keep_a = 1'b1; cls.keep_b = 1'b1;
      end
      MODE_LIST: cls.kind = K_LIST;
      default: known = 1'b0;
    endcase
  end

  assign in_stall = f_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = f_valid && !q_full;
  assign push_op  = f_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= known;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_op <= cls;
    end
  end

endmodule

// ===== rtl/core/smse_queue.sv =====
// Two-entry queue of classified operations between front and back end.
module smse_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  smse_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output smse_pkg::op_t q_op
);
  import smse_pkg::*;

  op_t        slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;

  assign full    = (cnt == 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_op    = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_op;
    end
  end

endmodule

// ===== rtl/core/smse_back.sv =====
// Back end: directory scan, merge walk, copy-back, listing and result register.
module smse_back #(
  parameter int NUM_SETS = 16,
  parameter int CAPACITY = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  smse_pkg::op_t  q_op,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output smse_pkg::rsp_t out_rsp
);
  import smse_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SETS);
  localparam int SCN_W  = $clog2(NUM_SETS + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int ADDR_W = $clog2(NUM_SETS * CAPACITY);
  localparam int DEPTH  = NUM_SETS * CAPACITY;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [SCN_W-1:0] LAST_SCN = SCN_W'(NUM_SETS);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_SCAN = 11'b00000000010,
    S_SEND = 11'b00000000100,
    S_MRD  = 11'b00000001000,
    S_MCMP = 11'b00000010000,
    S_CRD  = 11'b00000100000,
    S_CWR  = 11'b00001000000,
    S_UPD  = 11'b00010000000,
    S_LRD  = 11'b00100000000,
    S_LEM  = 11'b01000000000,
    S_RES  = 11'b10000000000
  } state_t;

  function automatic rsp_t mk_res(input logic [2:0] st, input logic [CNT_W-1:0] cnt,
                                  input logic mem);
    rsp_t r;
    r = '{status: st, count: cnt, is_member: mem, element: '0, last_of_run: 1'b1};
    return r;
  endfunction

  state_t state;
  op_t    op;
  logic   scan_b;
  logic   [SCN_W-1:0] scnt;
  logic   found;
  logic   [SLOT_W-1:0] fslot;
  logic   [CNT_W-1:0] fsize;
  logic   free_found;
  logic   [SLOT_W-1:0] free_slot;
  logic   [SLOT_W-1:0] sa;
  logic   [CNT_W-1:0] na;
  logic   [CNT_W-1:0] nb;
  logic   [ADDR_W-1:0] base_a;
  logic   [ADDR_W-1:0] base_b;
  logic   single_b;
  logic   [CNT_W-1:0] i;
  logic   [CNT_W-1:0] j;
  logic   [CNT_W-1:0] n;
  logic   [CNT_W-1:0] c;
  logic   ovf;
  logic   hit;
  logic   [NUM_SETS-1:0] set_valid;
  rsp_t   res;

  dir_ent_t dir_mem [NUM_SETS];
  dir_ent_t dir_rd;
  dir_ent_t dir_wdata;
  logic     dir_we;
  logic     [SLOT_W-1:0] dir_waddr;

  logic [VAL_W-1:0] elem_mem [DEPTH];
  logic [VAL_W-1:0] rd_a;
  logic [VAL_W-1:0] rd_b;
  logic [VAL_W-1:0] scr_mem [CAPACITY];
  logic [VAL_W-1:0] scr_rd;

  logic [ID_W-1:0]   cur_id;
  logic              create_ok;
  logic              slot_ok;
  logic [SLOT_W-1:0] slot_v;
  logic [CNT_W-1:0]  size_v;
  logic [ADDR_W-1:0] base_v;
  logic [SLOT_W-1:0] k;
  logic              ofree;
  logic              send_rsp;

  logic signed [VAL_W-1:0] av;
  logic signed [VAL_W-1:0] bv;
  logic a_ok;
  logic b_ok;
  logic pick_a;
  logic pick_b;
  logic take;
  logic [VAL_W-1:0] mv;

  assign cur_id    = scan_b ? op.id_b : op.id_a;
  assign create_ok = scan_b || (op.kind == K_INS) || (op.kind == K_SIZE) || (op.kind == K_TWO);
  assign slot_ok   = found || (create_ok && free_found);
  assign slot_v    = found ? fslot : free_slot;
  assign size_v    = found ? fsize : '0;
  assign base_v    = ADDR_W'(slot_v) * ADDR_W'(CAPACITY);
  assign k         = SLOT_W'(scnt - SCN_W'(1));
  assign ofree     = !out_valid || !out_stall;
  assign send_rsp  = ofree && (state == S_LEM || state == S_RES);
  assign pop       = (state == S_IDLE) && q_valid;

  always_comb begin
    a_ok   = i < na;
    b_ok   = j < nb;
    av     = $signed(rd_a);
    bv     = single_b ? op.value : $signed(rd_b);
    pick_a = !b_ok || (a_ok && (av < bv));
    pick_b = !pick_a && (!a_ok || (bv < av));
    take   = pick_a ? op.keep_a : (pick_b ? op.keep_b : op.keep_both);
    mv     = pick_b ? bv : av;
  end

  always_comb begin
    dir_we    = 1'b0;
    dir_waddr = free_slot;
    dir_wdata = '{id: cur_id, size: '0};
    if (state == S_UPD) begin
      dir_we    = 1'b1;
      dir_waddr = sa;
      dir_wdata = '{id: op.id_a, size: n};
    end else if (state == S_SEND && !found && create_ok && free_found) begin
      dir_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    dir_rd <= dir_mem[scnt[SLOT_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == S_CWR) begin
      elem_mem[base_a + ADDR_W'(c)] <= scr_rd;
    end
    rd_a <= elem_mem[base_a + ADDR_W'(i)];
    rd_b <= elem_mem[base_b + ADDR_W'(j)];
  end

  always_ff @(posedge clk) begin
    if (state == S_MCMP && take && n < CAP_C) begin
      scr_mem[n[IDX_W-1:0]] <= mv;
    end
    scr_rd <= scr_mem[c[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      set_valid <= '0;
    end else begin
      if (send_rsp) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            op         <= q_op;
            scan_b     <= 1'b0;
            scnt       <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scnt != '0) begin
            if (set_valid[k] && dir_rd.id == cur_id && !found) begin
              found <= 1'b1;
              fslot <= k;
              fsize <= dir_rd.size;
            end
            if (!set_valid[k] && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= k;
            end
          end
          if (scnt == LAST_SCN) begin
            state <= S_SEND;
          end else begin
            scnt <= scnt + SCN_W'(1);
          end
        end
        S_SEND: begin
          if (slot_ok && !found) begin
            set_valid[slot_v] <= 1'b1;
          end
          i   <= '0;
          j   <= '0;
          n   <= '0;
          ovf <= 1'b0;
          hit <= 1'b0;
          if (!scan_b) begin
            if (!slot_ok) begin
              res   <= mk_res(create_ok ? ST_OVF : (op.kind == K_LIST ? ST_EMPTY : ST_MISSING),
                              '0, 1'b0);
              state <= S_RES;
            end else begin
              sa     <= slot_v;
              na     <= size_v;
              base_a <= base_v;
              case (op.kind)
                K_SIZE: begin
                  res   <= mk_res(ST_SIZE, size_v, 1'b0);
                  state <= S_RES;
                end
                K_LIST: begin
                  if (size_v == '0) begin
                    res   <= mk_res(ST_EMPTY, '0, 1'b0);
                    state <= S_RES;
                  end else begin
                    state <= S_LRD;
                  end
                end
                K_TWO: begin
                  scan_b     <= 1'b1;
                  scnt       <= '0;
                  found      <= 1'b0;
                  free_found <= 1'b0;
                  state      <= S_SCAN;
                end
                default: begin
                  single_b <= 1'b1;
                  nb       <= CNT_W'(1);
                  state    <= S_MRD;
                end
              endcase
            end
          end else if (!slot_ok) begin
            res   <= mk_res(ST_OVF, na, 1'b0);
            state <= S_RES;
          end else begin
            nb       <= size_v;
            base_b   <= base_v;
            single_b <= 1'b0;
            state    <= S_MRD;
          end
        end
        S_MRD: begin
          if (i < na || j < nb) begin
            state <= S_MCMP;
          end else begin
            c <= '0;
            case (op.kind)
              K_MEM: begin
                res   <= mk_res(ST_MEMBER, na, hit);
                state <= S_RES;
              end
              K_INS: begin
                if (ovf) begin
                  res   <= mk_res(ST_OVF, na, 1'b0);
                  state <= S_RES;
                end else begin
                  state <= S_CRD;
                end
              end
              default: state <= S_CRD;
            endcase
          end
        end
        S_MCMP: begin
          if (pick_a || !pick_b) begin
            i <= i + CNT_W'(1);
          end
          if (!pick_a) begin
            j <= j + CNT_W'(1);
          end
          if (!pick_a && !pick_b) begin
            hit <= 1'b1;
          end
          if (take) begin
            if (n < CAP_C) begin
              n <= n + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
          state <= S_MRD;
        end
        S_CRD: begin
          state <= (c == n) ? S_UPD : S_CWR;
        end
        S_CWR: begin
          c     <= c + CNT_W'(1);
          state <= S_CRD;
        end
        S_UPD: begin
          res   <= mk_res((op.kind == K_TWO && ovf) ? ST_OVF : ST_SIZE, n, 1'b0);
          state <= S_RES;
        end
        S_LRD: begin
          state <= S_LEM;
        end
        S_LEM: begin
          if (ofree) begin
            out_rsp     <= '{status: ST_LISTED, count: na, is_member: 1'b0,
                             element: $signed(rd_a),
                             last_of_run: (i + CNT_W'(1) == na)};
            if (i + CNT_W'(1) == na) begin
              state <= S_IDLE;
            end else begin
              i     <= i + CNT_W'(1);
              state <= S_LRD;
            end
          end
        end
        S_RES: begin
          if (ofree) begin
            out_rsp   <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/smse_checker.sv =====
// Port checker for the sorted multi-set engine and its bind.
module smse_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_stall,
  input smse_pkg::rsp_t out_rsp
);
  import smse_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("stalled response changed");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_rsp.status == ST_EMPTY || out_rsp.status == ST_MISSING)
      |-> out_rsp.count == '0)
    else $error("empty or missing result with nonzero count");

  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rsp.status != ST_LISTED |-> out_rsp.last_of_run)
    else $error("single result not marked last");

  a_member: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rsp.status != ST_MEMBER |-> !out_rsp.is_member)
    else $error("membership flag outside member result");

endmodule

bind sorted_multi_set_engine smse_checker u_smse_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_rsp   (out_rsp)
);

// ===== tb/sv/tb_sorted_multi_set_engine.sv =====
// Testbench for the sorted multi-set engine: directed and random requests checked against a behavioral model.
`timescale 1ns / 100ps
module tb_sorted_multi_set_engine;
  import smse_pkg::*;

  localparam int NSETS = 16;
  localparam int CAP   = 32;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_rsp;

  sorted_multi_set_engine #(.NUM_SETS(NSETS), .CAPACITY(CAP)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp)
  );

  logic [15:0] dir_id [NSETS];
  bit          dir_used [NSETS];
  int          dir_size [NSETS];
  logic [31:0] elems [NSETS][CAP];

  rsp_t pending_rsp[$];
  int   errors = 0;
  int   cycles = 0;
  bit   idle_en = 1'b1;
  int   hold_cycles = 0;
  bit   long_hold = 1'b0;
  event long_hold_ev;

  initial forever #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report(input string what, input rsp_t got, input rsp_t exp);
    $display("mismatch %s: got %p expected %p", what, got, exp);
    errors++;
  endtask

  function automatic int find_slot(logic [15:0] id);
    for (int s = 0; s < NSETS; s++)
      if (dir_used[s] && dir_id[s] == id) return s;
    return -1;
  endfunction

  function automatic int make_slot(logic [15:0] id);
    int s;
    s = find_slot(id);
    if (s >= 0) return s;
    for (int k = 0; k < NSETS; k++)
      if (!dir_used[k]) begin
        dir_used[k] = 1'b1;
        dir_id[k] = id;
        dir_size[k] = 0;
        return k;
      end
    return -1;
  endfunction

  function automatic void push_rsp(logic [2:0] st, int cnt, bit mem, logic [31:0] el, bit last);
    rsp_t r;
    r.status = st;
    r.count = cnt[6:0];
    r.is_member = mem;
    r.element = el;
    r.last_of_run = last;
    pending_rsp = {pending_rsp, r};
  endfunction

  function automatic bit merge_sets(int sa, int sb, bit ka, bit kb, bit kboth);
    logic [31:0] ta[CAP], tb[CAP], res[CAP];
    int na, nb, i, j, n;
    bit ovf, take;
    logic [31:0] v;
    na = dir_size[sa]; nb = dir_size[sb]; i = 0; j = 0; n = 0; ovf = 0;
    for (int k = 0; k < CAP; k++) begin
      ta[k] = elems[sa][k]; tb[k] = elems[sb][k];
    end
    while (i < na || j < nb) begin
      if (j >= nb || (i < na && $signed(ta[i]) < $signed(tb[j]))) begin
        v = ta[i]; i++; take = ka;
      end else if (i >= na || $signed(tb[j]) < $signed(ta[i])) begin
        v = tb[j]; j++; take = kb;
      end else begin
        v = ta[i]; i++; j++; take = kboth;
      end
      if (take) begin
        if (n < CAP) begin
          res[n] = v; n++;
        end else ovf = 1;
      end
    end
    for (int k = 0; k < n; k++) elems[sa][k] = res[k];
    dir_size[sa] = n;
    return ovf;
  endfunction

  function automatic void predict_set_op(req_t r);
    int sa, sb, n, pos;
    bit ovf;
    case (r.mode)
      MODE_INSERT: begin
        sa = make_slot(r.set_a);
        if (sa < 0) begin
          push_rsp(ST_OVF, 0, 0, 0, 1); return;
        end
        n = dir_size[sa]; pos = 0;
        while (pos < n && $signed(elems[sa][pos]) < $signed(r.item_value)) pos++;
        if (pos < n && elems[sa][pos] == r.item_value) push_rsp(ST_SIZE, n, 0, 0, 1);
        else if (n >= CAP) push_rsp(ST_OVF, n, 0, 0, 1);
        else begin
          for (int i = n; i > pos; i--) elems[sa][i] = elems[sa][i-1];
          elems[sa][pos] = r.item_value;
          dir_size[sa] = n + 1;
          push_rsp(ST_SIZE, n + 1, 0, 0, 1);
        end
      end
      MODE_DELETE, MODE_MEMBER: begin
        sa = find_slot(r.set_a);
        if (sa < 0) begin
          push_rsp(ST_MISSING, 0, 0, 0, 1); return;
        end
        n = dir_size[sa]; pos = 0;
        while (pos < n && elems[sa][pos] != r.item_value) pos++;
        if (r.mode == MODE_MEMBER) push_rsp(ST_MEMBER, n, pos < n, 0, 1);
        else begin
          if (pos < n) begin
            for (int i = pos; i + 1 < n; i++) elems[sa][i] = elems[sa][i+1];
            n--; dir_size[sa] = n;
          end
          push_rsp(ST_SIZE, n, 0, 0, 1);
        end
      end
      MODE_SIZE: begin
        sa = make_slot(r.set_a);
        if (sa < 0) push_rsp(ST_OVF, 0, 0, 0, 1);
        else push_rsp(ST_SIZE, dir_size[sa], 0, 0, 1);
      end
      MODE_UNION, MODE_INTER, MODE_DIFF, MODE_SYMD: begin
        sa = make_slot(r.set_a);
        if (sa < 0) begin
          push_rsp(ST_OVF, 0, 0, 0, 1); return;
        end
        sb = make_slot(r.set_b);
        if (sb < 0) begin
          push_rsp(ST_OVF, dir_size[sa], 0, 0, 1); return;
        end
        case (r.mode)
          MODE_UNION: ovf = merge_sets(sa, sb, 1, 1, 1);
          MODE_INTER: ovf = merge_sets(sa, sb, 0, 0, 1);
          MODE_DIFF:  ovf = merge_sets(sa, sb, 1, 0, 0);
          default:    ovf = merge_sets(sa, sb, 1, 1, 0);
        endcase
        push_rsp(ovf ? ST_OVF : ST_SIZE, dir_size[sa], 0, 0, 1);
      end
      MODE_LIST: begin
        sa = find_slot(r.set_a);
        if (sa < 0 || dir_size[sa] == 0) push_rsp(ST_EMPTY, 0, 0, 0, 1);
        else begin
          n = dir_size[sa];
          for (int i = 0; i < n; i++) push_rsp(ST_LISTED, n, 0, elems[sa][i], i + 1 == n);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    rsp_t exp;
    if (!rst && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        report("unexpected response", out_rsp, '0);
      end else begin
        exp = pending_rsp.pop_front();
        if (out_rsp.status !== exp.status) report("status", out_rsp, exp);
        if (out_rsp.count !== exp.count) report("count", out_rsp, exp);
        if (out_rsp.is_member !== exp.is_member) report("is_member", out_rsp, exp);
        if (out_rsp.element !== exp.element) report("element", out_rsp, exp);
        if (out_rsp.last_of_run !== exp.last_of_run) report("last_of_run", out_rsp, exp);
      end
    end
  end

  initial forever begin
    @(long_hold_ev);
    long_hold = 1'b1;
    repeat (600) @(negedge clk);
    long_hold = 1'b0;
  end

  always @(negedge clk) begin
    if (long_hold) begin
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      hold_cycles <= $urandom_range(0, 4);
    end else out_stall <= 1'b0;
  end

  task automatic send_req(input logic [3:0] mode, input logic [15:0] a, input logic [15:0] b,
                          input logic [31:0] v);
    req_t r;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    r.mode = mode; r.set_a = a; r.set_b = b; r.item_value = v;
    in_req <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_set_op(r);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic test_directed;
    send_req(MODE_LIST, 16'h0, 0, 0);
    send_req(MODE_MEMBER, 16'hFFFF, 0, 5);
    send_req(MODE_DELETE, 16'h1234, 0, 5);
    send_req(MODE_INSERT, 16'hFFFF, 0, 32'h7FFFFFFF);
    send_req(MODE_INSERT, 16'hFFFF, 0, 32'h80000000);
    send_req(MODE_INSERT, 16'hFFFF, 0, 32'h0);
    send_req(MODE_INSERT, 16'hFFFF, 0, 32'h0);
    send_req(MODE_MEMBER, 16'hFFFF, 0, 32'h80000000);
    send_req(MODE_MEMBER, 16'hFFFF, 0, 32'hFFFFFFFF);
    send_req(MODE_DELETE, 16'hFFFF, 0, 32'h1);
    send_req(MODE_LIST, 16'hFFFF, 0, 0);
    send_req(MODE_SIZE, 16'h0000, 0, 0);
    send_req(MODE_UNION, 16'h0000, 16'hFFFF, 0);
    send_req(MODE_INTER, 16'h0000, 16'h0000, 0);
    send_req(MODE_DIFF, 16'h0000, 16'h5555, 0);
    send_req(MODE_SYMD, 16'hAAAA, 16'hFFFF, 0);
    send_req(MODE_SYMD, 16'hFFFF, 16'hFFFF, 0);
    send_req(4'd9, 16'hFFFF, 0, 0);
    send_req(4'd15, 16'hFFFF, 0, 0);
    send_req(MODE_DELETE, 16'hAAAA, 0, 32'h7FFFFFFF);
    send_req(MODE_LIST, 16'hAAAA, 0, 0);
    drain();
  endtask

  task automatic test_capacity;
    for (int i = 0; i < CAP + 2; i++) send_req(MODE_INSERT, 16'd1, 0, i * 3);
    for (int i = 0; i < CAP; i++) send_req(MODE_INSERT, 16'd2, 0, i * 3 + 1);
    send_req(MODE_UNION, 16'd1, 16'd2, 0);
    send_req(MODE_LIST, 16'd1, 0, 0);
    send_req(MODE_SYMD, 16'd2, 16'd1, 0);
    drain();
  endtask

  task automatic test_directory_full;
    for (int i = 0; i < NSETS + 2; i++) send_req(MODE_SIZE, 16'h100 + i, 0, 0);
    send_req(MODE_INSERT, 16'h7777, 0, 1);
    send_req(MODE_UNION, 16'd1, 16'h7777, 0);
    send_req(MODE_UNION, 16'h7777, 16'd1, 0);
    drain();
  endtask

  function automatic logic [15:0] pick_id();
    return (NSETS > 0 && $urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
  endfunction

  task automatic random_items(input int n);
    logic [3:0] m;
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: m = MODE_INSERT;
        3: m = MODE_DELETE;
        4: m = MODE_MEMBER;
        5: m = MODE_LIST;
        6: m = MODE_SIZE;
        7, 8: m = 4'($urandom_range(0, 3)) == 0 ? MODE_UNION :
                  ($urandom_range(0, 2) == 0 ? MODE_INTER :
                  ($urandom_range(0, 1) ? MODE_DIFF : MODE_SYMD));
        default: m = 4'($urandom);
      endcase
      v = $urandom_range(0, 3) == 0 ? $urandom : 32'($signed($urandom_range(0, 40)) - 20);
      send_req(m, pick_id(), pick_id(), v);
    end
  endtask

  task automatic test_random_mixed;
    rst_dir_fresh();
    random_items(200);
    drain();
  endtask

  task automatic rst_dir_fresh;
  endtask

  task automatic test_backpressure;
    -> long_hold_ev;
    for (int i = 0; i < 20; i++) send_req(MODE_INSERT, 16'd3, 0, $urandom);
    send_req(MODE_LIST, 16'd3, 0, 0);
    drain();
  endtask

  task automatic test_no_idle;
    idle_en = 1'b0;
    random_items(150);
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_capacity();
    test_directory_full();
    test_random_mixed();
    test_backpressure();
    test_no_idle();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    for (int s = 0; s < NSETS; s++) begin
      dir_used[s] = 1'b0;
      dir_size[s] = 0;
    end
  end

endmodule

// ===== sorted_multi_set_engine.f =====
rtl/core/smse_pkg.sv
rtl/core/smse_front.sv
rtl/core/smse_queue.sv
rtl/core/smse_back.sv
rtl/core/sorted_multi_set_engine.sv
rtl/core/smse_checker.sv
tb/sv/tb_sorted_multi_set_engine.sv
